// File: design/ptas_pkg.sv
// Shared types and codes for the prime test and search block.
// No dependencies; used by ptas_mod and prime_test_and_search.
package ptas_pkg;

  localparam logic [1:0] MODE_TEST = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_stat_t;

endpackage

// File: design/ptas_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on ptas_pkg (mod_stat_t).
module ptas_mod #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [W-1:0]        dividend,
  input  logic [W-1:0]        divisor,
  output ptas_pkg::mod_stat_t stat
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic          done;
  logic [W-1:0]  sh;
  logic [W-1:0]  dv;
  logic [W-1:0]  rem;
  logic [W-1:0]  rem_next;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;

  always_comb begin
    trial = {rem, sh[W-1]};
    if (trial >= {1'b0, dv}) begin
      rem_next = W'(trial - {1'b0, dv});
    end else begin
      rem_next = W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= dividend;
        dv   <= divisor;
        rem  <= '0;
        cnt  <= CW'(W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        sh  <= {sh[W-2:0], 1'b0};
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.zero = (rem == '0);

endmodule

// File: design/prime_test_and_search.sv
// Prime test (6k+-1 trial division), next prime at or above, previous prime below.
// Depends on ptas_pkg and ptas_mod (bit-serial remainder unit).
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  item in | mode, value                    | taken when start & !busy
//  result  | answer, prime_flag, overflow   | valid for one cycle with done
//
// Each trial divisor runs through the serial remainder unit, and each 6k+-1 pair adds
// one bound check before its two divisors.
// A search repeats the test for every odd candidate up to the prime it finds.
// busy rises in the cycle after an item is taken and falls in the cycle that carries
// done; rst (synchronous) idles the block. The receiver cannot stall.
module prime_test_and_search #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  mode,
  input  logic [31:0] value,
  output logic        busy,
  output logic        done,
  output logic [31:0] answer,
  output logic        prime_flag,
  output logic        overflow
);

  localparam int W = VALUE_WIDTH;
  localparam logic [W-1:0] TOP = {W{1'b1}};

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SETUP   = 3'd1;
  localparam logic [2:0] S_TEST    = 3'd2;
  localparam logic [2:0] S_WAIT3   = 3'd3;
  localparam logic [2:0] S_CHK     = 3'd4;
  localparam logic [2:0] S_WAITA   = 3'd5;
  localparam logic [2:0] S_WAITB   = 3'd6;
  localparam logic [2:0] S_VERDICT = 3'd7;

  logic [2:0]   state;
  logic [1:0]   mode_r;
  logic [W-1:0] cand;
  logic [W-1:0] d;
  logic [W+1:0] dsq;
  logic         cand_prime;

  logic                mod_start;
  logic [W-1:0]        mod_div;
  ptas_pkg::mod_stat_t mod_stat;

  always_comb begin
    mod_start = 1'b0;
    mod_div   = d;
    unique case (state)
      S_TEST: begin
        mod_start = (cand > W'(3)) && cand[0];
        mod_div   = W'(3);
      end
      S_CHK: begin
        mod_start = !(dsq > {2'b00, cand});
        mod_div   = d;
      end
      S_WAITA: begin
        mod_start = mod_stat.done && !mod_stat.zero;
        mod_div   = d + W'(2);
      end
      default: begin
        mod_start = 1'b0;
        mod_div   = d;
      end
    endcase
  end

  ptas_mod #(.W(W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (cand),
    .divisor  (mod_div),
    .stat     (mod_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode_r <= mode;
            cand   <= W'(value);
            state  <= S_SETUP;
          end
        end
        S_SETUP: begin
          answer     <= '0;
          prime_flag <= 1'b0;
          overflow   <= 1'b0;
          if (mode_r == ptas_pkg::MODE_TEST) begin
            state <= S_TEST;
          end else if (mode_r == ptas_pkg::MODE_UP) begin
            if (cand <= W'(2)) begin
              answer <= 32'd2;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              cand  <= cand | W'(1);
              state <= S_TEST;
            end
          end else if (mode_r == ptas_pkg::MODE_DOWN) begin
            if (cand <= W'(2)) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (cand == W'(3)) begin
              answer <= 32'd2;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              cand  <= cand[0] ? cand - W'(2) : cand - W'(1);
              state <= S_TEST;
            end
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_TEST: begin
          if (cand <= W'(1)) begin
            cand_prime <= 1'b0;
            state      <= S_VERDICT;
          end else if (cand <= W'(3)) begin
            cand_prime <= 1'b1;
            state      <= S_VERDICT;
          end else if (!cand[0]) begin
            cand_prime <= 1'b0;
            state      <= S_VERDICT;
          end else begin
            state <= S_WAIT3;
          end
        end
        S_WAIT3: begin
          if (mod_stat.done) begin
            if (mod_stat.zero) begin
              cand_prime <= 1'b0;
              state      <= S_VERDICT;
            end else begin
              d     <= W'(5);
              dsq   <= (W+2)'(25);
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (dsq > {2'b00, cand}) begin
            cand_prime <= 1'b1;
            state      <= S_VERDICT;
          end else begin
            state <= S_WAITA;
          end
        end
        S_WAITA: begin
          if (mod_stat.done) begin
            if (mod_stat.zero) begin
              cand_prime <= 1'b0;
              state      <= S_VERDICT;
            end else begin
              state <= S_WAITB;
            end
          end
        end
        S_WAITB: begin
          if (mod_stat.done) begin
            if (mod_stat.zero) begin
              cand_prime <= 1'b0;
              state      <= S_VERDICT;
            end else begin
              d     <= d + W'(6);
              dsq   <= dsq + ({2'b00, d} << 3) + ({2'b00, d} << 2) + (W+2)'(36);
              state <= S_CHK;
            end
          end
        end
        S_VERDICT: begin
          if (mode_r == ptas_pkg::MODE_TEST) begin
            prime_flag <= cand_prime;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (mode_r == ptas_pkg::MODE_UP) begin
            if (cand_prime) begin
              answer <= 32'(cand);
              done   <= 1'b1;
              state  <= S_IDLE;
            end else if (cand > TOP - W'(2)) begin
              overflow <= 1'b1;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else begin
              cand  <= cand + W'(2);
              state <= S_TEST;
            end
          end else begin
            if (cand_prime) begin
              answer <= 32'(cand);
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              cand  <= cand - W'(2);
              state <= S_TEST;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: tb/sv/tb_top.sv
// Testbench for prime_test_and_search: directed and random items across all modes.
// Depends on ptas_pkg and the prime_test_and_search RTL; a ledger class predicts
// each answer by trial division and checks the results in order.
module tb_top;

  localparam int VW = 32;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [31:0] answer;
    logic        prime_flag;
    logic        overflow;
  } prime_result_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [31:0]   value;
    prime_result_t want;
  } pending_query_t;

  class prime_ledger;
    pending_query_t pending_answers[$];
    int mismatches;
    int answers_checked;
    int items_by_mode[4];
    int overflows_seen;
    int primes_seen;

    function longint unsigned top_value();
      return (64'd1 << VW) - 1;
    endfunction

    function bit trial_prime(longint unsigned n);
      longint unsigned d;
      if (n <= 1) return 1'b0;
      if (n <= 3) return 1'b1;
      if (n % 2 == 0 || n % 3 == 0) return 1'b0;
      for (d = 5; d <= n / d; d += 6)
        if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
      return 1'b1;
    endfunction

    function longint unsigned prime_at_or_above(longint unsigned n, output bit ovf);
      longint unsigned c;
      ovf = 1'b0;
      if (n <= 2) return 2;
      c = n | 64'd1;
      while (!trial_prime(c)) begin
        if (c > top_value() - 2) begin
          ovf = 1'b1;
          return 0;
        end
        c += 2;
      end
      return c;
    endfunction

    function longint unsigned prime_below(longint unsigned n);
      longint unsigned c;
      if (n <= 2) return 0;
      if (n == 3) return 2;
      c = (n % 2 == 0) ? n - 1 : n - 2;
      while (!trial_prime(c)) c -= 2;
      return c;
    endfunction

    function void note_item(logic [1:0] m, logic [31:0] v);
      pending_query_t q;
      longint unsigned n;
      bit ovf;
      n = longint'(v) & top_value();
      q.mode = m;
      q.value = v;
      q.want = '0;
      case (m)
        ptas_pkg::MODE_TEST: q.want.prime_flag = trial_prime(n);
        ptas_pkg::MODE_UP: begin
          q.want.answer = 32'(prime_at_or_above(n, ovf));
          q.want.overflow = ovf;
        end
        ptas_pkg::MODE_DOWN: q.want.answer = 32'(prime_below(n));
        default: ;
      endcase
      items_by_mode[m]++;
      pending_answers.push_back(q);
    endfunction

    function void check_answer(prime_result_t got);
      pending_query_t q;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result answer %0d prime_flag %0b overflow %0b",
                 $time, got.answer, got.prime_flag, got.overflow);
        mismatches++;
        return;
      end
      q = pending_answers.pop_front();
      answers_checked++;
      if (got.overflow === 1'b1) overflows_seen++;
      if (got.prime_flag === 1'b1) primes_seen++;
      if (got.answer !== q.want.answer) begin
        $display("%0t: mode %0d value %0d: answer expected %0d actual %0d",
                 $time, q.mode, q.value, q.want.answer, got.answer);
        mismatches++;
      end
      if (got.prime_flag !== q.want.prime_flag) begin
        $display("%0t: mode %0d value %0d: prime_flag expected %0b actual %0b",
                 $time, q.mode, q.value, q.want.prime_flag, got.prime_flag);
        mismatches++;
      end
      if (got.overflow !== q.want.overflow) begin
        $display("%0t: mode %0d value %0d: overflow expected %0b actual %0b",
                 $time, q.mode, q.value, q.want.overflow, got.overflow);
        mismatches++;
      end
    endfunction

    function void summarize();
      if (pending_answers.size() != 0) begin
        $display("%0t: %0d items never answered", $time, pending_answers.size());
        mismatches += pending_answers.size();
      end
      $display("Covered %0d tests, %0d up searches, %0d down searches, %0d unused-mode items;",
               items_by_mode[0], items_by_mode[1], items_by_mode[2], items_by_mode[3]);
      $display("%0d answers checked, %0d primes flagged, %0d overflows, %0d mismatches.",
               answers_checked, primes_seen, overflows_seen, mismatches);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic [1:0]  mode;
  logic [31:0] value;
  logic        busy;
  logic        done;
  logic [31:0] answer;
  logic        prime_flag;
  logic        overflow;

  int          idle_pct;
  prime_ledger ledger;

  prime_test_and_search #(.VALUE_WIDTH(VW)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .value      (value),
    .busy       (busy),
    .done       (done),
    .answer     (answer),
    .prime_flag (prime_flag),
    .overflow   (overflow)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) ledger.check_answer({answer, prime_flag, overflow});
  end

  task automatic offer_item(input logic [1:0] m, input logic [31:0] v);
    mode  <= m;
    value <= v;
    start <= ($urandom_range(0, 99) >= idle_pct);
    @(posedge clk);
    while (!(start && !busy)) begin
      start <= ($urandom_range(0, 99) >= idle_pct);
      @(posedge clk);
    end
    ledger.note_item(m, v);
  endtask

  task automatic wait_all_answered();
    @(posedge clk);
    while (ledger.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand(logic [1:0] m);
    logic [31:0] r;
    int w;
    r = $urandom;
    if (m == MODE_SPARE) return r;
    if (m == ptas_pkg::MODE_TEST && $urandom_range(0, 3) == 0)
      return r - r % $urandom_range(3, 7);
    w = ($urandom_range(0, 11) == 0) ? 24 : $urandom_range(1, 16);
    return r & ((32'd1 << w) - 1);
  endfunction

  task automatic run_directed();
    idle_pct = 12;
    offer_item(ptas_pkg::MODE_TEST, 32'd0);  offer_item(ptas_pkg::MODE_TEST, 32'd1);
    offer_item(ptas_pkg::MODE_TEST, 32'd2);  offer_item(ptas_pkg::MODE_TEST, 32'd3);
    offer_item(ptas_pkg::MODE_TEST, 32'd4);  offer_item(ptas_pkg::MODE_TEST, 32'd25);
    offer_item(ptas_pkg::MODE_TEST, 32'd35); offer_item(ptas_pkg::MODE_TEST, 32'd49);
    offer_item(ptas_pkg::MODE_TEST, 32'd97);
    offer_item(ptas_pkg::MODE_TEST, 32'hFFFF_FFFF);
    offer_item(ptas_pkg::MODE_TEST, 32'h8000_0000);
    offer_item(ptas_pkg::MODE_UP, 32'd0);  offer_item(ptas_pkg::MODE_UP, 32'd2);
    offer_item(ptas_pkg::MODE_UP, 32'd3);  offer_item(ptas_pkg::MODE_UP, 32'd24);
    offer_item(ptas_pkg::MODE_UP, 32'hFFFF_FFFE);
    offer_item(ptas_pkg::MODE_UP, 32'hFFFF_FFFF);
    offer_item(ptas_pkg::MODE_DOWN, 32'd0); offer_item(ptas_pkg::MODE_DOWN, 32'd2);
    offer_item(ptas_pkg::MODE_DOWN, 32'd3); offer_item(ptas_pkg::MODE_DOWN, 32'd4);
    offer_item(ptas_pkg::MODE_DOWN, 32'hFFFF_FFFF);
    offer_item(MODE_SPARE, 32'd0);
    offer_item(MODE_SPARE, 32'hFFFF_FFFF);
    start <= 1'b0;
    wait_all_answered();
  endtask

  task automatic run_random(input int count, input int pct);
    logic [1:0] m;
    int pick;
    idle_pct = pct;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      m = (pick < 3) ? ptas_pkg::MODE_TEST :
          (pick < 6) ? ptas_pkg::MODE_UP :
          (pick < 9) ? ptas_pkg::MODE_DOWN : MODE_SPARE;
      offer_item(m, random_operand(m));
    end
    start <= 1'b0;
    wait_all_answered();
  endtask

  initial begin
    ledger = new();
    rst = 1'b1;
    start = 1'b0;
    mode = ptas_pkg::MODE_TEST;
    value = '0;
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(26, 12);
    run_random(25, 51);
    run_random(25, 0);
    ledger.summarize();
    if (ledger.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("%0t: timeout with %0d items unanswered", $time, ledger.pending_answers.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
